// ----- hdl/pending_request_timeout_table_defines.svh -----
// assertion macros for the pending request timeout table
// expects clk and arst_n in the scope of each use
`ifndef PENDING_REQUEST_TIMEOUT_TABLE_DEFINES_SVH
`define PENDING_REQUEST_TIMEOUT_TABLE_DEFINES_SVH

// same-cycle implication
`define PRTT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PRTT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/prtt_pkg.sv -----
// shared types and codes for the pending request timeout table
// no dependencies
package prtt_pkg;

	localparam int unsigned TOKEN_W  = 64;
	localparam int unsigned LIFE_W   = 16;
	localparam int unsigned PERIOD_W = 12;
	localparam int unsigned OP_W     = 2;
	localparam int unsigned STATUS_W = 2;

	localparam logic [OP_W-1:0] OP_TRACK    = 2'd0;
	localparam logic [OP_W-1:0] OP_RESPONSE = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK     = 2'd2;
	localparam logic [OP_W-1:0] OP_SHUTDOWN = 2'd3;

	localparam logic [STATUS_W-1:0] ST_COMPLETED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EXPIRED    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_CANCELLED  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd3;

	localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST = 12'd1;

	typedef struct packed {
		logic [TOKEN_W-1:0]  token;
		logic [STATUS_W-1:0] status;
	} res_t;

	// sequencer to output stage
	typedef struct packed {
		logic emit;
		logic flush;
		res_t res;
	} emit_req_t;

	// output stage to sequencer
	typedef struct packed {
		logic pend_v;
		logic out_free;
	} out_sts_t;

endpackage

// ----- hdl/prtt_out.sv -----
// output stage: one held-back result plus the output register
// depends on prtt_pkg
module prtt_out import prtt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  emit_req_t emit_req,
	input  logic      out_stall,
	output logic      out_valid,
	output res_t      out_res,
	output logic      out_last,
	output out_sts_t  out_sts
);

	logic pend_v_q;
	res_t pend_q;
	logic out_valid_q;
	res_t out_q;
	logic last_q;
	logic out_free;
	logic load_mid;
	logic load_last;

	assign out_free  = !out_valid_q || !out_stall;
	// a newer result pushes the held one out as not-last
	assign load_mid  = emit_req.emit && pend_v_q;
	// end of item: held result goes out as last
	assign load_last = emit_req.flush && !emit_req.emit && pend_v_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_req.emit) begin
				pend_v_q <= 1'b1;
			end else if (load_last) begin
				pend_v_q <= 1'b0;
			end
			if (load_mid || load_last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_req.emit) begin
			pend_q <= emit_req.res;
		end
		if (load_mid) begin
			out_q  <= pend_q;
			last_q <= 1'b0;
		end else if (load_last) begin
			out_q  <= pend_q;
			last_q <= 1'b1;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_res          = out_q;
	assign out_last         = last_q;
	assign out_sts.pend_v   = pend_v_q;
	assign out_sts.out_free = out_free;

endmodule

// ----- hdl/prtt_ctrl.sv -----
// slot sequencer with token and ttl memories and valid flops
// depends on prtt_pkg and pending_request_timeout_table_defines.svh
`include "pending_request_timeout_table_defines.svh"
module prtt_ctrl import prtt_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = 16,
	parameter int unsigned TOKEN_BITS  = 64,
	parameter int unsigned IDX_W       = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [OP_W-1:0]     operation,
	input  logic [TOKEN_W-1:0]  token,
	input  logic [LIFE_W-1:0]   lifetime,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [PERIOD_W-1:0] tick_period,
	output emit_req_t           emit_req,
	input  out_sts_t            out_sts
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FIN   = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	logic [TOKEN_BITS-1:0] tok_mem [TABLE_DEPTH];
	logic [LIFE_W-1:0]     ttl_mem [TABLE_DEPTH];

	logic [1:0]             state_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [IDX_W-1:0]       idx_q;
	logic [OP_W-1:0]        op_q;
	logic                   found_q;
	logic                   free_found_q;
	logic [IDX_W-1:0]       free_idx_q;
	logic [TOKEN_BITS-1:0]  tok_q;
	logic [LIFE_W-1:0]      life_q;
	logic [PERIOD_W-1:0]    tick_period_q;

	logic [TOKEN_BITS-1:0] rd_token_s1;
	logic [LIFE_W-1:0]     rd_ttl_s1;

	logic                  in_acc;
	logic [IDX_W-1:0]      rd_addr;
	logic                  adv;
	logic                  emit_want;
	logic                  emit_fire;
	res_t                  emit_res;
	logic                  clr_v;
	logic                  tok_we;
	logic                  ttl_we;
	logic [IDX_W-1:0]      wr_addr;
	logic [LIFE_W-1:0]     wr_ttl;
	logic                  slot_v;
	logic                  hit;
	logic [LIFE_W-1:0]     period_ext;
	logic [LIFE_W-1:0]     ttl_new;

	assign in_acc    = in_valid && (state_q == ST_IDLE);
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	assign slot_v     = valid_q[idx_q];
	assign hit        = slot_v && (rd_token_s1 == tok_q);
	assign period_ext = LIFE_W'(tick_period_q);
	assign ttl_new    = (rd_ttl_s1 > period_ext) ? (rd_ttl_s1 - period_ext) : '0;

	always_comb begin
		emit_want       = 1'b0;
		emit_res.token  = TOKEN_W'(rd_token_s1);
		emit_res.status = ST_COMPLETED;
		clr_v           = 1'b0;
		tok_we          = 1'b0;
		ttl_we          = 1'b0;
		wr_addr         = idx_q;
		wr_ttl          = ttl_new;
		case (state_q)
			ST_SCAN: begin
				case (op_q)
					OP_TRACK: begin
						emit_want = 1'b0;
					end
					OP_RESPONSE: begin
						if (hit) begin
							emit_want       = 1'b1;
							emit_res.status = ST_COMPLETED;
							clr_v           = 1'b1;
						end
					end
					OP_TICK: begin
						if (slot_v) begin
							if (ttl_new == '0) begin
								emit_want       = 1'b1;
								emit_res.status = ST_EXPIRED;
								clr_v           = 1'b1;
							end else begin
								ttl_we = 1'b1;
							end
						end
					end
					default: begin
						if (slot_v) begin
							emit_want       = 1'b1;
							emit_res.status = ST_CANCELLED;
							clr_v           = 1'b1;
						end
					end
				endcase
			end
			ST_FIN: begin
				if (op_q == OP_TRACK && !found_q) begin
					if (free_found_q) begin
						tok_we  = 1'b1;
						ttl_we  = 1'b1;
						wr_addr = free_idx_q;
						wr_ttl  = life_q;
					end else begin
						emit_want       = 1'b1;
						emit_res.token  = TOKEN_W'(tok_q);
						emit_res.status = ST_TABLE_FULL;
					end
				end
			end
			default: begin
				emit_want = 1'b0;
			end
		endcase
	end

	// hold the slot while a new result has nowhere to go
	assign adv       = !(emit_want && out_sts.pend_v && !out_sts.out_free);
	assign emit_fire = emit_want && adv;

	// read address: next slot when moving on, same slot to re-read while held
	always_comb begin
		rd_addr = idx_q;
		if (state_q == ST_IDLE) begin
			rd_addr = '0;
		end else if (state_q == ST_SCAN && adv && idx_q != LAST_IDX) begin
			rd_addr = idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_we && adv) begin
			tok_mem[wr_addr] <= tok_q;
		end
		rd_token_s1 <= tok_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ttl_we && adv) begin
			ttl_mem[wr_addr] <= wr_ttl;
		end
		rd_ttl_s1 <= ttl_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			valid_q       <= '0;
			idx_q         <= '0;
			op_q          <= OP_TRACK;
			found_q       <= 1'b0;
			free_found_q  <= 1'b0;
			tick_period_q <= TICK_PERIOD_RST;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tick_period_q <= tick_period;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						op_q         <= operation;
						idx_q        <= '0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (adv) begin
						if (clr_v) begin
							valid_q[idx_q] <= 1'b0;
						end
						if (op_q == OP_TRACK && hit) begin
							found_q <= 1'b1;
						end
						if (!slot_v && !free_found_q) begin
							free_found_q <= 1'b1;
						end
						if (idx_q == LAST_IDX) begin
							state_q <= ST_FIN;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_FIN: begin
					if (adv) begin
						if (tok_we) begin
							valid_q[free_idx_q] <= 1'b1;
						end
						state_q <= ST_FLUSH;
					end
				end
				default: begin
					if (!out_sts.pend_v) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			tok_q  <= token[TOKEN_BITS-1:0];
			life_q <= lifetime;
		end
		if (state_q == ST_SCAN && adv && !slot_v && !free_found_q) begin
			free_idx_q <= idx_q;
		end
	end

	assign emit_req.emit  = emit_fire;
	assign emit_req.flush = (state_q == ST_FLUSH);
	assign emit_req.res   = emit_res;

	`PRTT_ASSERT_IMP(a_emit_room, emit_fire && out_sts.pend_v, out_sts.out_free,
		"result emitted while held result cannot move out")
	`PRTT_ASSERT_NXT(a_emit_held, emit_fire, out_sts.pend_v,
		"emitted result not held by output stage")
	`PRTT_ASSERT_IMP(a_idle_drained, state_q == ST_IDLE, !out_sts.pend_v,
		"idle with an undelivered result")
	`PRTT_ASSERT_IMP(a_insert_free, state_q == ST_FIN && tok_we, !valid_q[free_idx_q],
		"insert into a live slot")

endmodule

// ----- hdl/pending_request_timeout_table.sv -----
// pending request timeout table top level; uses prtt_pkg, prtt_ctrl, prtt_out
// all slots are scanned one per cycle unless the output stage holds the scan, then a
// finish state inserts or reports table full and a flush state drains the last word;
// a new item is taken only when idle, after the scan, finish and drain of the last one
// reset: valid flops cleared (table empty), tick_period back to 1, memories left unwritten
module pending_request_timeout_table import prtt_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = 16,
	parameter int unsigned TOKEN_BITS  = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	// request channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [OP_W-1:0]     operation,
	input  logic [TOKEN_W-1:0]  token,
	input  logic [LIFE_W-1:0]   lifetime,
	// result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [TOKEN_W-1:0]  result_token,
	output logic [STATUS_W-1:0] status,
	output logic                last,
	// tick period register write
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [PERIOD_W-1:0] tick_period
);

	// slot index width, at least one bit for a single-slot table
	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	emit_req_t emit_req;
	out_sts_t  out_sts;
	res_t      out_res;

	// sequencer: reads one slot per cycle unless held by the output stage, updates ttl and valid, inserts at the end
	prtt_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.TOKEN_BITS  (TOKEN_BITS),
		.IDX_W       (IDX_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.token       (token),
		.lifetime    (lifetime),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.tick_period (tick_period),
		.emit_req    (emit_req),
		.out_sts     (out_sts)
	);

	// output stage: holds the newest result back until it is known whether it is last
	prtt_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit_req  (emit_req),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_res   (out_res),
		.out_last  (last),
		.out_sts   (out_sts)
	);

	assign result_token = out_res.token;
	assign status       = out_res.status;

endmodule
